### rtl/sbh_pkg.sv
// SHA-256 byte-stream hasher: shared types, round constants, initial hash values
// and the sigma functions. No dependencies.
`timescale 1ns / 1ps

package sbh_pkg;

	typedef logic [31:0] word_t;

	// Controls from the sequencer to the compression core
	typedef struct packed {
		logic       load;     // copy hash words into working variables
		logic       prep;     // schedule word at idx enters the schedule
		logic [5:0] idx;      // schedule index being prepared
		logic       round;    // run one compression round
		logic       fold;     // add working variables into hash words
		logic       restart;  // hash words back to initial values
	} core_ctrl_t;

	function automatic word_t round_k(input logic [5:0] i);
		word_t k;
		case (i)
			6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
			default: k = 32'h00000000;
		endcase
		return k;
	endfunction

	function automatic word_t hash_iv(input logic [2:0] i);
		word_t h;
		case (i)
			3'd0: h = 32'h6a09e667;
			3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372;
			3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f;
			3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab;
			3'd7: h = 32'h5be0cd19;
			default: h = 32'h00000000;
		endcase
		return h;
	endfunction

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

### rtl/sbh_buffer.sv
// SHA-256 byte-stream hasher: 64-byte block buffer, 16 words of 32 bits,
// byte-wise writes, one registered word read per cycle. Uses sbh_pkg.
`timescale 1ns / 1ps

module sbh_buffer (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [5:0]    wr_pos,
	input  logic [7:0]    wr_byte,
	input  logic [3:0]    rd_addr,
	output sbh_pkg::word_t rd_data
);
	import sbh_pkg::*;

	word_t mem_q [16];
	word_t rd_data_q;

	// First byte of a word lands in its most significant lane
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/sbh_core.sv
// SHA-256 byte-stream hasher: compression core with hash words, working
// variables, 16-word schedule window and one round per cycle. Uses sbh_pkg.
`timescale 1ns / 1ps

module sbh_core (
	input  logic               clk,
	input  logic               arst_n,
	input  sbh_pkg::core_ctrl_t ctrl,
	input  sbh_pkg::word_t     w_in,
	input  logic [2:0]         emit_idx,
	output sbh_pkg::word_t     hash_word
);
	import sbh_pkg::*;

	word_t hash_q  [8];
	word_t v_q     [8];
	word_t sched_q [16];
	word_t kw_q;

	word_t w_sched, w_new;
	word_t t1, t2, ch, maj;

	// Expanded schedule word from the window (sched_q[0] is W[t-16])
	always_comb begin
		w_sched = small_sigma1(sched_q[14]) + sched_q[9]
			+ small_sigma0(sched_q[1]) + sched_q[0];
		w_new = (ctrl.idx[5:4] == 2'b00) ? w_in : w_sched;
	end

	// Round function on the working variables
	always_comb begin
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1  = v_q[7] + big_sigma1(v_q[4]) + ch + kw_q;
		t2  = big_sigma0(v_q[0]) + maj;
	end

	// Hash words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= hash_iv(3'(i));
		end else if (ctrl.restart) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= hash_iv(3'(i));
		end else if (ctrl.fold) begin
			for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
		end
	end

	// Working variables
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
		end else if (ctrl.round) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	// Schedule window and K+W one round ahead
	always_ff @(posedge clk) begin
		if (ctrl.prep) begin
			for (int i = 0; i < 15; i++) sched_q[i] <= sched_q[i+1];
			sched_q[15] <= w_new;
			kw_q        <= round_k(ctrl.idx) + w_new;
		end
	end

	assign hash_word = hash_q[emit_idx];

endmodule

### rtl/sha256_byte_stream_hasher_unit.sv
// SHA-256 byte-stream hasher, top level: sequencer, padding on the buffer
// read path and digest output register. Uses sbh_pkg, sbh_buffer, sbh_core.
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------------
//  input   | in_valid / in_stall | op[1:0], data_byte[7:0]
//  output  | out_valid/out_stall | digest_word[31:0], word_index, last_word
//
// A byte that does not complete a block keeps the unit idle. Each 64-byte
// block runs through the shared round unit (a read-ahead and load step, then
// schedule preparation, 64 rounds and a fold), during which in_stall is high.
// A finish runs one or two padded blocks (two when more than 55 bytes are
// pending, plus a data block if op 1 completes one), then emits 8 items.
// Input stays stalled until the last digest word is taken. Reset sets the
// initial hash values and clears the counters; no clearing pass is needed.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sbh_pkg::*;

	localparam logic [1:0] OP_APPEND        = 2'd0;
	localparam logic [1:0] OP_APPEND_FINISH = 2'd1;
	localparam logic [1:0] OP_FINISH        = 2'd2;

	typedef enum logic [2:0] {ST_IDLE, ST_PRE, ST_RUN, ST_FIN, ST_EMIT} state_t;
	typedef enum logic [1:0] {BLK_DATA, BLK_PAD1, BLK_PAD2} blk_t;

	state_t      state_q;
	blk_t        kind_q;
	logic        fin_q;
	logic [6:0]  cnt_q;
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [3:0]  sel_q;
	logic        out_valid_q;
	word_t       digest_q;
	logic [2:0]  index_q;
	logic        last_q;

	logic        in_acc, out_acc, wr_en;
	logic [3:0]  rd_addr;
	word_t       rd_data, w_in, hash_word;
	core_ctrl_t  ctrl;
	logic [6:0]  lim;
	logic        put80, putlen;
	logic [5:0]  pos;
	logic [7:0]  mem_b, len_b;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign wr_en    = in_acc && (op == OP_APPEND || op == OP_APPEND_FINISH);

	// Block buffer
	sbh_buffer u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_pos  (fill_q),
		.wr_byte (data_byte),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Read one word ahead of the schedule
	assign rd_addr = (state_q == ST_PRE) ? 4'd0 : 4'(cnt_q[3:0] + 4'd1);

	// Padding is applied on the read path; the buffer itself is never padded
	always_comb begin
		case (kind_q)
			BLK_DATA: begin lim = 7'd64;           put80 = 1'b0; putlen = 1'b0;              end
			BLK_PAD1: begin lim = {1'b0, fill_q};  put80 = 1'b1; putlen = (fill_q <= 6'd55); end
			BLK_PAD2: begin lim = 7'd0;            put80 = 1'b0; putlen = 1'b1;              end
			default:  begin lim = 7'd64;           put80 = 1'b0; putlen = 1'b0;              end
		endcase
		w_in  = '0;
		pos   = '0;
		mem_b = '0;
		len_b = '0;
		for (int j = 0; j < 4; j++) begin
			pos   = {cnt_q[3:0], 2'(j)};
			mem_b = rd_data[31 - 8*j -: 8];
			len_b = 8'(bits_q >> {~pos[2:0], 3'b000});
			if ({1'b0, pos} < lim) begin
				w_in[31 - 8*j -: 8] = mem_b;
			end else if (put80 && {1'b0, pos} == lim) begin
				w_in[31 - 8*j -: 8] = 8'h80;
			end else if (putlen && pos >= 6'd56) begin
				w_in[31 - 8*j -: 8] = len_b;
			end else begin
				w_in[31 - 8*j -: 8] = 8'h00;
			end
		end
	end

	// Core controls
	always_comb begin
		ctrl.load    = (state_q == ST_PRE);
		ctrl.prep    = (state_q == ST_RUN) && !cnt_q[6];
		ctrl.idx     = cnt_q[5:0];
		ctrl.round   = (state_q == ST_RUN) && (cnt_q != 7'd0);
		ctrl.fold    = (state_q == ST_FIN);
		ctrl.restart = out_acc && last_q;
	end

	sbh_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.w_in      (w_in),
		.emit_idx  (sel_q[2:0]),
		.hash_word (hash_word)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= BLK_DATA;
			fin_q       <= 1'b0;
			cnt_q       <= '0;
			fill_q      <= '0;
			bits_q      <= '0;
			sel_q       <= '0;
			out_valid_q <= 1'b0;
			digest_q    <= '0;
			index_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (op)
							OP_APPEND: begin
								fill_q <= 6'(fill_q + 6'd1);
								bits_q <= bits_q + 64'd8;
								if (fill_q == 6'd63) begin
									kind_q  <= BLK_DATA;
									fin_q   <= 1'b0;
									state_q <= ST_PRE;
								end
							end
							OP_APPEND_FINISH: begin
								fill_q  <= 6'(fill_q + 6'd1);
								bits_q  <= bits_q + 64'd8;
								fin_q   <= 1'b1;
								kind_q  <= (fill_q == 6'd63) ? BLK_DATA : BLK_PAD1;
								state_q <= ST_PRE;
							end
							OP_FINISH: begin
								fin_q   <= 1'b1;
								kind_q  <= BLK_PAD1;
								state_q <= ST_PRE;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PRE: begin
					cnt_q   <= '0;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd64) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (kind_q == BLK_DATA && fin_q) begin
						kind_q  <= BLK_PAD1;
						state_q <= ST_PRE;
					end else if (kind_q == BLK_PAD1 && fill_q > 6'd55) begin
						kind_q  <= BLK_PAD2;
						state_q <= ST_PRE;
					end else if (kind_q != BLK_DATA) begin
						sel_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_acc && last_q) begin
						out_valid_q <= 1'b0;
						last_q      <= 1'b0;
						fin_q       <= 1'b0;
						fill_q      <= '0;
						bits_q      <= '0;
						state_q     <= ST_IDLE;
					end else if (!out_valid_q || out_acc) begin
						out_valid_q <= 1'b1;
						digest_q    <= hash_word;
						index_q     <= sel_q[2:0];
						last_q      <= (sel_q == 4'd7);
						sel_q       <= sel_q + 4'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_word = digest_q;
	assign word_index  = index_q;
	assign last_word   = last_q;

	// Input is held off while a digest is being delivered
	a_stall_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while digest pending");

	// Last word taken: ready for a new message with an empty buffer
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_word) |=> (!in_stall && fill_q == 6'd0))
		else $error("no restart after last digest word");

	// Round counter stays within one block
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (cnt_q <= 7'd64))
		else $error("round counter overran");

	// Digest words follow each other without gaps
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_word) |=>
			(out_valid && word_index == 3'($past(word_index) + 3'd1)))
		else $error("digest word out of order");

endmodule

### verif/sbh_tb_pkg.sv
// Operation codes of the hasher input item, shared by the stimulus and the checker.
// No dependencies.
`timescale 1ns / 1ps

package sbh_tb_pkg;

	typedef enum logic [1:0] {
		OP_APPEND        = 2'd0,
		OP_APPEND_FINISH = 2'd1,
		OP_FINISH        = 2'd2,
		OP_UNUSED        = 2'd3
	} hash_op_t;

endpackage

### verif/sbh_digest_checker.sv
// Digest checker: watches both channels, runs its own SHA-256 of the byte stream
// and compares every digest word. Uses sbh_pkg (word_t) and sbh_tb_pkg (op codes).
`timescale 1ns / 1ps

module sbh_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          mismatch_count,
	output int          words_outstanding
);
	import sbh_pkg::*;
	import sbh_tb_pkg::*;

	localparam logic [64*32-1:0] ROUND_CONSTS = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [8*32-1:0] START_HASH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		word_t      word;
		logic [2:0] index;
		logic       is_last;
	} expected_digest_t;

	// predicted hasher state
	word_t       chain_hash [8];
	logic [7:0]  msg_block [64];
	logic [5:0]  block_fill;
	logic [63:0] msg_bit_len;

	expected_digest_t digest_queue [$];

	function automatic word_t rotr(input word_t v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic void restart_chain();
		for (int k = 0; k < 8; k++)
			chain_hash[k] = START_HASH[(7 - k) * 32 +: 32];
		block_fill = 6'd0;
		msg_bit_len = 64'd0;
	endfunction

	// one 64-round compression of msg_block into chain_hash
	function automatic void mix_block();
		word_t sched [64];
		word_t a, b, c, d, e, f, g, h, t1, t2;
		for (int t = 0; t < 16; t++)
			sched[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
		for (int t = 16; t < 64; t++)
			sched[t] = sched[t-16] + sched[t-7]
				+ (rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3))
				+ (rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10));
		a = chain_hash[0];
		b = chain_hash[1];
		c = chain_hash[2];
		d = chain_hash[3];
		e = chain_hash[4];
		f = chain_hash[5];
		g = chain_hash[6];
		h = chain_hash[7];
		for (int t = 0; t < 64; t++) begin
			t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
				+ ROUND_CONSTS[(63 - t) * 32 +: 32] + sched[t];
			t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g;
			g = f;
			f = e;
			e = d + t1;
			d = c;
			c = b;
			b = a;
			a = t1 + t2;
		end
		chain_hash[0] = chain_hash[0] + a;
		chain_hash[1] = chain_hash[1] + b;
		chain_hash[2] = chain_hash[2] + c;
		chain_hash[3] = chain_hash[3] + d;
		chain_hash[4] = chain_hash[4] + e;
		chain_hash[5] = chain_hash[5] + f;
		chain_hash[6] = chain_hash[6] + g;
		chain_hash[7] = chain_hash[7] + h;
	endfunction

	// apply one accepted item; a finish queues the eight digest words
	function automatic void absorb_item(input hash_op_t kind, input logic [7:0] b);
		int pos;
		expected_digest_t word_exp;
		if (kind == OP_UNUSED)
			return;
		if (kind != OP_FINISH) begin
			msg_block[block_fill] = b;
			block_fill = block_fill + 6'd1;
			msg_bit_len = msg_bit_len + 64'd8;
			if (block_fill == 6'd0)
				mix_block();
		end
		if (kind == OP_APPEND)
			return;
		// padding: marker byte, zeros, then the big-endian bit length
		pos = int'(block_fill);
		msg_block[pos] = 8'h80;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				msg_block[pos] = 8'h00;
				pos++;
			end
			mix_block();
			pos = 0;
		end
		while (pos < 56) begin
			msg_block[pos] = 8'h00;
			pos++;
		end
		for (int k = 0; k < 8; k++)
			msg_block[56 + k] = msg_bit_len[63 - 8 * k -: 8];
		mix_block();
		for (int k = 0; k < 8; k++) begin
			word_exp.word = chain_hash[k];
			word_exp.index = k[2:0];
			word_exp.is_last = (k == 7);
			digest_queue.push_back(word_exp);
		end
		restart_chain();
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t checker: %s: got %h expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_digest_word();
		expected_digest_t want;
		if (digest_queue.size() == 0) begin
			report_mismatch("digest word with no finish pending", digest_word, 32'd0);
			return;
		end
		want = digest_queue.pop_front();
		if (digest_word !== want.word)
			report_mismatch("digest_word", digest_word, want.word);
		if (word_index !== want.index)
			report_mismatch("word_index", {29'd0, word_index}, {29'd0, want.index});
		if (last_word !== want.is_last)
			report_mismatch("last_word", {31'd0, last_word}, {31'd0, want.is_last});
	endtask

	// sample both channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_chain();
			digest_queue.delete();
			mismatch_count = 0;
			words_outstanding <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_digest_word();
			if (in_valid && !in_stall)
				absorb_item(hash_op_t'(op), data_byte);
			words_outstanding <= digest_queue.size();
		end
	end

endmodule

### verif/testbench.sv
// Top of the hasher testbench: clock, reset, byte-stream stimulus and output stalls.
// Uses sbh_tb_pkg, sbh_digest_checker and the sha256_byte_stream_hasher_unit RTL.
`timescale 1ns / 1ps

module testbench;
	import sbh_tb_pkg::*;

	localparam int RANDOM_ITEMS = 280;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = OP_APPEND;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          mismatch_count;
	int          words_outstanding;

	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit hold_go = 1'b0;
	bit rx_hold = 1'b0;
	int items_sent = 0;

	always #5 clk = ~clk;

	sha256_byte_stream_hasher_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	sbh_digest_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.op                (op),
		.data_byte         (data_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.digest_word       (digest_word),
		.word_index        (word_index),
		.last_word         (last_word),
		.mismatch_count    (mismatch_count),
		.words_outstanding (words_outstanding)
	);

	// receiver: random stalls, a calm stretch, and one long hold-off
	always @(posedge clk) begin
		if (rx_hold)
			out_stall <= 1'b1;
		else if (rx_calm)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(0, 99) < 37);
	end

	// long hold-off of the output, counted here
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// offer one item, idling first at random; returns at the accepting edge
	task automatic send_item(input hash_op_t kind, input logic [7:0] b);
		while (!tx_calm && $urandom_range(0, 99) < 37) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		data_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (kind != OP_UNUSED)
			items_sent++;
	endtask

	// one whole message with random bytes and the odd ignored item mixed in
	task automatic send_message(input int len);
		bit byte_finish;
		byte_finish = (len != 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 4)
				send_item(OP_UNUSED, 8'($urandom_range(0, 255)));
			if (byte_finish && i == len - 1)
				send_item(OP_APPEND_FINISH, 8'($urandom_range(0, 255)));
			else
				send_item(OP_APPEND, 8'($urandom_range(0, 255)));
		end
		if (!byte_finish)
			send_item(OP_FINISH, 8'($urandom_range(0, 255)));
	endtask

	task automatic wait_for_digests();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_outstanding != 0)
			@(posedge clk);
	endtask

	// mostly short messages, some mid-length, the rest around the one- and two-block padding edges
	function automatic int pick_length();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 12);
			4:          return 55;
			5:          return 56;
			6:          return $urandom_range(57, 64);
			7:          return $urandom_range(13, 54);
			8:          return $urandom_range(119, 120);
			default:    return $urandom_range(0, 3);
		endcase
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored opcode, empty messages, "abc", byte extremes
		send_item(OP_UNUSED, 8'hff);
		send_item(OP_FINISH, 8'hff);
		send_item(OP_FINISH, 8'h00);
		send_item(OP_APPEND, 8'h61);
		send_item(OP_APPEND, 8'h62);
		send_item(OP_APPEND_FINISH, 8'h63);
		send_item(OP_APPEND_FINISH, 8'h00);
		send_item(OP_APPEND_FINISH, 8'hff);
		send_item(OP_APPEND, 8'h80);
		send_item(OP_UNUSED, 8'h00);
		send_item(OP_APPEND, 8'h7f);
		send_item(OP_FINISH, 8'h5a);
		send_item(OP_APPEND, 8'h01);
		send_item(OP_UNUSED, 8'haa);
		send_item(OP_APPEND_FINISH, 8'hfe);
		wait_for_digests();

		// random messages
		items_sent = 0;
		for (int m = 0; items_sent < RANDOM_ITEMS; m++) begin
			if (m == 2)
				hold_go <= 1'b1;
			if (m == 5) begin
				tx_calm = 1'b1;
				rx_calm <= 1'b1;
			end
			if (m == 8) begin
				tx_calm = 1'b0;
				rx_calm <= 1'b0;
			end
			// short message while the output is held, then keep pushing
			send_message((m == 2) ? 3 : pick_length());
			if (m % 4 == 3)
				wait_for_digests();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (words_outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

### sim.f
rtl/sbh_pkg.sv
rtl/sbh_buffer.sv
rtl/sbh_core.sv
rtl/sha256_byte_stream_hasher_unit.sv
verif/sbh_tb_pkg.sv
verif/sbh_digest_checker.sv
verif/testbench.sv
